// File: design/dleo_pkg.sv
// ----------------------------------------------------------------------------
// dleo_pkg
// Shared types and constants for the line-program extended opcode parser.
// ----------------------------------------------------------------------------
package dleo_pkg;

    localparam int MAX_BUFFER_BYTES = 65536;
    // holds MAX_BUFFER_BYTES + 1, the marker for an oversized length
    localparam int CNT_W            = $clog2(MAX_BUFFER_BYTES + 2);
    localparam int ARG_W            = 64;
    localparam int LEB_CNT_W        = 4;
    localparam int LEB_MAX_GROUPS   = 10;
    localparam int CFG_DATA_W       = 4;
    localparam int CFG_INDEX_W      = 2;
    localparam int DWARF_V5         = 5;

    typedef logic [CNT_W-1:0] t_cnt;

    // parser phases
    localparam logic [3:0] PH_LEN    = 4'd0;
    localparam logic [3:0] PH_OPC    = 4'd1;
    localparam logic [3:0] PH_ADDR   = 4'd2;
    localparam logic [3:0] PH_DISC   = 4'd3;
    localparam logic [3:0] PH_NAME   = 4'd4;
    localparam logic [3:0] PH_TSTART = 4'd5;
    localparam logic [3:0] PH_TRAIL  = 4'd6;
    localparam logic [3:0] PH_WAIT   = 4'd7;
    localparam logic [3:0] PH_DRAIN  = 4'd8;

    // extended opcodes
    localparam logic [7:0] OP_SET_ADDRESS       = 8'd2;
    localparam logic [7:0] OP_DEFINE_FILE       = 8'd3;
    localparam logic [7:0] OP_SET_DISCRIMINATOR = 8'd4;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_LENGTH = 2'd1;
    localparam logic [1:0] ST_TRUNCATED  = 2'd2;

    // result kinds
    localparam logic KIND_NAME  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_VERSION      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_ADDRESS_SIZE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_ADDRESS_SIZE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIG_ENDIAN_MODE     = 2'd3;

    typedef struct packed {
        logic [2:0] header_version;
        logic [3:0] header_address_size;
        logic [3:0] target_address_size;
        logic       big_endian_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        header_version:      3'd4,
        header_address_size: 4'd8,
        target_address_size: 4'd8,
        big_endian_mode:     1'b0
    };

    typedef struct packed {
        logic [3:0]           phase;
        logic [ARG_W-1:0]     leb_acc;
        logic [LEB_CNT_W-1:0] leb_cnt;      // also the address byte index
        t_cnt                 op_len;
        t_cnt                 bytes_seen;
        logic [7:0]           opcode;
        logic [3:0]           addr_left;
        logic [1:0]           trail_idx;
        logic [ARG_W-1:0]     arg;
        logic                 arg_seen;
        t_cnt                 received;
    } t_state;

    localparam t_state STATE_IDLE = '0;

    typedef struct packed {
        logic             kind;
        logic [7:0]       opcode;
        logic [ARG_W-1:0] argument;
        logic             arg_valid;
        logic [7:0]       name_byte;
        t_cnt             bytes_used;
        logic [1:0]       status;
    } t_result;

endpackage

// File: design/dleo_leb.sv
// ----------------------------------------------------------------------------
// dleo_leb
// One ULEB128 byte into the accumulator; groups past bit 63 are dropped.
// ----------------------------------------------------------------------------
module dleo_leb (
    input  logic [dleo_pkg::ARG_W-1:0]     i_acc,
    input  logic [dleo_pkg::LEB_CNT_W-1:0] i_cnt,
    input  logic [7:0]                     i_byte,
    output logic [dleo_pkg::ARG_W-1:0]     o_acc,
    output logic [dleo_pkg::LEB_CNT_W-1:0] o_cnt,
    output logic                           o_done
);
    import dleo_pkg::*;

    logic [6:0]       leb_shift;
    logic [ARG_W-1:0] group;

    assign leb_shift = {3'b000, i_cnt} * 7'd7;
    assign group     = {{(ARG_W-7){1'b0}}, i_byte[6:0]} << leb_shift;

    always_comb begin
        if (i_cnt >= LEB_CNT_W'(LEB_MAX_GROUPS)) begin
            // eleventh byte closes the number whatever its top bit
            o_acc  = i_acc;
            o_cnt  = i_cnt;
            o_done = 1'b1;
        end else begin
            o_acc  = i_acc | group;
            o_cnt  = i_cnt + LEB_CNT_W'(1);
            o_done = ~i_byte[7];
        end
    end

endmodule

// File: design/dleo_step.sv
// ----------------------------------------------------------------------------
// dleo_step
// Next-state and result logic for one buffer byte.
// ----------------------------------------------------------------------------
module dleo_step (
    input  dleo_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  dleo_pkg::t_cfg    i_cfg,
    output dleo_pkg::t_state  o_state,
    output logic              o_emit,
    output dleo_pkg::t_result o_result
);
    import dleo_pkg::*;

    function automatic logic [3:0] addr_size(input t_cfg cfg);
        logic [3:0] s;
        s = (cfg.header_version >= 3'(DWARF_V5)) ? cfg.header_address_size
                                                 : cfg.target_address_size;
        if (s == 4'd0)
            return 4'd1;
        if (s > 4'd8)
            return 4'd8;
        return s;
    endfunction

    t_cnt                 recv;
    logic [ARG_W-1:0]     leb_acc_in;
    logic [LEB_CNT_W-1:0] leb_cnt_in;
    logic [ARG_W-1:0]     leb_acc_new;
    logic [LEB_CNT_W-1:0] leb_cnt_new;
    logic                 leb_done;
    logic [3:0]           left_new;
    logic                 fin;
    logic [1:0]           fin_status;
    t_cnt                 fin_used;
    logic [7:0]           fin_nb;
    logic                 bad;
    logic                 item_done;

    assign recv = (i_state.received < t_cnt'(MAX_BUFFER_BYTES))
                ? i_state.received + t_cnt'(1) : i_state.received;

    // a trailing field starts from a clear accumulator
    assign leb_acc_in = (i_state.phase == PH_TSTART) ? '0 : i_state.leb_acc;
    assign leb_cnt_in = (i_state.phase == PH_TSTART) ? '0 : i_state.leb_cnt;

    assign left_new = (i_state.addr_left != 4'd0) ? i_state.addr_left - 4'd1
                                                  : i_state.addr_left;

    dleo_leb u_leb (
        .i_acc  (leb_acc_in),
        .i_cnt  (leb_cnt_in),
        .i_byte (i_byte),
        .o_acc  (leb_acc_new),
        .o_cnt  (leb_cnt_new),
        .o_done (leb_done)
    );

    always_comb begin
        o_state    = i_state;
        o_state.received = recv;
        o_emit     = 1'b0;
        o_result   = '0;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_used   = '0;
        fin_nb     = 8'd0;
        bad        = 1'b0;
        item_done  = 1'b0;

        case (i_state.phase)
            PH_LEN: begin
                if (leb_done) begin
                    if (leb_acc_new == '0 || i_last) begin
                        bad = 1'b1;
                    end else begin
                        if (leb_acc_new > ARG_W'(MAX_BUFFER_BYTES))
                            o_state.op_len = t_cnt'(MAX_BUFFER_BYTES + 1);
                        else
                            o_state.op_len = recv + leb_acc_new[CNT_W-1:0];
                        o_state.leb_acc = '0;
                        o_state.leb_cnt = '0;
                        o_state.phase   = PH_OPC;
                    end
                end else begin
                    o_state.leb_acc = leb_acc_new;
                    o_state.leb_cnt = leb_cnt_new;
                    if (i_last)
                        bad = 1'b1;
                end
            end
            PH_OPC: begin
                o_state.opcode   = i_byte;
                o_state.arg      = '0;
                o_state.arg_seen = 1'b0;
                o_state.leb_acc  = '0;
                o_state.leb_cnt  = '0;
                case (i_byte)
                    OP_SET_ADDRESS: begin
                        o_state.addr_left = addr_size(i_cfg);
                        o_state.phase     = PH_ADDR;
                    end
                    OP_DEFINE_FILE: begin
                        o_state.phase = PH_NAME;
                    end
                    OP_SET_DISCRIMINATOR: begin
                        o_state.phase = PH_DISC;
                    end
                    default: begin
                        // unknown opcode: skip to the end of its length
                        fin      = 1'b1;
                        fin_used = i_state.op_len;
                    end
                endcase
                if (o_state.phase != PH_OPC && i_last) begin
                    fin        = 1'b1;
                    fin_status = ST_TRUNCATED;
                    fin_used   = recv;
                end
            end
            PH_ADDR: begin
                if (i_cfg.big_endian_mode)
                    o_state.arg = {i_state.arg[ARG_W-9:0], i_byte};
                else
                    o_state.arg = i_state.arg
                                | ({{(ARG_W-8){1'b0}}, i_byte}
                                   << {i_state.leb_cnt[2:0], 3'b000});
                o_state.leb_cnt   = i_state.leb_cnt + LEB_CNT_W'(1);
                o_state.addr_left = left_new;
                if (left_new == 4'd0) begin
                    o_state.arg_seen = 1'b1;
                    fin      = 1'b1;
                    fin_used = recv;
                end else if (i_last) begin
                    o_state.arg = '0;
                    fin         = 1'b1;
                    fin_status  = ST_TRUNCATED;
                    fin_used    = recv;
                end
            end
            PH_DISC: begin
                o_state.leb_acc = leb_acc_new;
                o_state.leb_cnt = leb_cnt_new;
                if (leb_done) begin
                    o_state.arg      = leb_acc_new;
                    o_state.arg_seen = 1'b1;
                    fin      = 1'b1;
                    fin_used = recv;
                end else if (i_last) begin
                    fin        = 1'b1;
                    fin_status = ST_TRUNCATED;
                    fin_used   = recv;
                end
            end
            PH_NAME: begin
                if (i_byte == 8'd0) begin
                    if (i_last) begin
                        fin      = 1'b1;
                        fin_used = recv;
                    end else begin
                        o_state.trail_idx = 2'd0;
                        o_state.phase     = PH_TSTART;
                    end
                end else if (i_last) begin
                    // name cut by buffer end: the final word carries the byte
                    fin        = 1'b1;
                    fin_status = ST_TRUNCATED;
                    fin_used   = recv;
                    fin_nb     = i_byte;
                end else begin
                    o_emit             = 1'b1;
                    o_result.kind      = KIND_NAME;
                    o_result.opcode    = i_state.opcode;
                    o_result.name_byte = i_byte;
                    o_result.status    = ST_OK;
                end
            end
            PH_TSTART, PH_TRAIL: begin
                if (i_state.phase == PH_TSTART && i_last) begin
                    // field would start on the last byte: not read, not counted
                    fin      = 1'b1;
                    fin_used = recv - t_cnt'(1);
                end else begin
                    o_state.leb_acc = leb_acc_new;
                    o_state.leb_cnt = leb_cnt_new;
                    if (leb_done) begin
                        if (i_state.trail_idx == 2'd0) begin
                            o_state.arg      = leb_acc_new;
                            o_state.arg_seen = 1'b1;
                        end
                        if (i_state.trail_idx >= 2'd2 || i_last) begin
                            fin      = 1'b1;
                            fin_used = recv;
                        end else begin
                            o_state.trail_idx = i_state.trail_idx + 2'd1;
                            o_state.phase     = PH_TSTART;
                        end
                    end else if (i_last) begin
                        fin        = 1'b1;
                        fin_status = ST_TRUNCATED;
                        fin_used   = recv;
                    end else begin
                        o_state.phase = PH_TRAIL;
                    end
                end
            end
            PH_WAIT: begin
                fin      = 1'b1;
                fin_used = i_state.bytes_seen;
            end
            default: begin
                // drain: ignore bytes up to the end of the buffer
                if (i_last)
                    o_state = STATE_IDLE;
            end
        endcase

        // final word waits until the length field is covered
        if (fin) begin
            if (recv < i_state.op_len) begin
                if (i_last) begin
                    bad = 1'b1;
                end else begin
                    o_state.bytes_seen = fin_used;
                    o_state.phase      = PH_WAIT;
                end
            end else begin
                o_emit             = 1'b1;
                o_result.kind      = KIND_FINAL;
                o_result.opcode    = o_state.opcode;
                o_result.argument  = o_state.arg_seen ? o_state.arg : '0;
                o_result.arg_valid = o_state.arg_seen;
                o_result.name_byte = fin_nb;
                o_result.bytes_used = fin_used;
                o_result.status    = fin_status;
                item_done          = 1'b1;
            end
        end

        if (bad) begin
            o_emit          = 1'b1;
            o_result        = '0;
            o_result.kind   = KIND_FINAL;
            o_result.status = ST_BAD_LENGTH;
            item_done       = 1'b1;
        end

        if (item_done) begin
            if (i_last)
                o_state = STATE_IDLE;
            else
                o_state.phase = PH_DRAIN;
        end
    end

endmodule

// File: design/dwarf_line_ext_opcode_parser.sv
// Path: an accepted byte is held in the input register, and its result word in the result register.
// Throughput: one byte per cycle; the input register advances whenever the
//   result register is empty or being taken in the same cycle.
// At most one result word per byte, so a full result register is the only stall.
// Reset (synchronous, active low): parser back to waiting for a length field,
//   byte count zero, both registers empty, config to version 4, sizes 8, LE.
// ----------------------------------------------------------------------------
// dwarf_line_ext_opcode_parser
// Byte-stream parser for one line-program extended operation per buffer.
// ----------------------------------------------------------------------------
module dwarf_line_ext_opcode_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dleo_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [dleo_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_last_in_buffer,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_result_kind,
    output logic [7:0]                         o_opcode_value,
    output logic [dleo_pkg::ARG_W-1:0]         o_argument,
    output logic                               o_argument_valid,
    output logic [7:0]                         o_name_byte,
    output logic [dleo_pkg::CNT_W-1:0]         o_bytes_used,
    output logic [1:0]                         o_status
);
    import dleo_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    n_in_valid;
    logic [7:0] r_in_byte;
    logic    r_in_last;
    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    logic    step_fire;
    logic    step_emit;
    t_result step_result;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER_VERSION:      r_cfg.header_version      <= i_cfg_data[2:0];
                CFG_HEADER_ADDRESS_SIZE: r_cfg.header_address_size <= i_cfg_data[3:0];
                CFG_TARGET_ADDRESS_SIZE: r_cfg.target_address_size <= i_cfg_data[3:0];
                CFG_BIG_ENDIAN_MODE:     r_cfg.big_endian_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign step_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step_fire;
    assign n_in_valid = o_in_ready ? i_in_valid : r_in_valid;

    always_comb begin
        if (step_fire)
            n_out_valid = step_emit;
        else if (i_out_ready)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    dleo_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_IDLE;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (step_fire)
                r_state <= n_state;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_in_buffer;
        end
        if (step_fire && step_emit)
            r_out <= step_result;
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out.kind;
    assign o_opcode_value   = r_out.opcode;
    assign o_argument       = r_out.argument;
    assign o_argument_valid = r_out.arg_valid;
    assign o_name_byte      = r_out.name_byte;
    assign o_bytes_used     = r_out.bytes_used;
    assign o_status         = r_out.status;

    a_received_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.received <= t_cnt'(MAX_BUFFER_BYTES))
        else $error("byte count past buffer limit");

    a_name_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_NAME |->
            r_out.status == ST_OK && r_out.bytes_used == '0 && !r_out.arg_valid)
        else $error("name word carries final fields");

    a_bad_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_BAD_LENGTH |->
            r_out.kind == KIND_FINAL && r_out.opcode == 8'd0 &&
            r_out.bytes_used == '0 && !r_out.arg_valid)
        else $error("bad length word carries data");

    a_arg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.arg_valid |-> r_out.argument == '0)
        else $error("argument set without valid");

    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && step_emit && step_result.kind == KIND_FINAL && !r_in_last |=>
            r_state.phase == PH_DRAIN)
        else $error("final word did not close the operation");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && r_in_last && (n_state.phase != PH_WAIT) |=>
            r_state.received == '0 || r_state.phase == PH_WAIT)
        else $error("buffer end did not restart the parser");

endmodule

// File: bench/tb_dwarf_line_ext_opcode_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dwarf_line_ext_opcode_parser
// Self-checking bench for the extended opcode parser. Buffers are fed one
// word per byte, and an in-bench parser predicts every result word. Covers
// each opcode, bad and odd length fields, truncation, address size and byte
// order settings, random traffic with idle gaps and receiver stalls, a long
// receiver hold-off, and buffers past the byte counter's saturation point.
// ----------------------------------------------------------------------------
module tb_dwarf_line_ext_opcode_parser;
    import dleo_pkg::*;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_PATTERN} t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [7:0]             i_data_byte;
    logic                   i_last_in_buffer;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic                   o_result_kind;
    logic [7:0]             o_opcode_value;
    logic [ARG_W-1:0]       o_argument;
    logic                   o_argument_valid;
    logic [7:0]             o_name_byte;
    logic [CNT_W-1:0]       o_bytes_used;
    logic [1:0]             o_status;

    dwarf_line_ext_opcode_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_in_buffer (i_last_in_buffer),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_opcode_value   (o_opcode_value),
        .o_argument       (o_argument),
        .o_argument_valid (o_argument_valid),
        .o_name_byte      (o_name_byte),
        .o_bytes_used     (o_bytes_used),
        .o_status         (o_status)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("tb_dwarf_line_ext_opcode_parser: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------
    t_cfg            cfg;
    logic [3:0]      stage;
    longint unsigned leb_acc, arg_val, op_end, held_used, rx_count;
    int unsigned     leb_shift, addr_left, field_idx;
    logic [7:0]      opc_seen;
    logic            arg_ok;

    t_result pending_results[$];

    int n_errors = 0;
    int n_results = 0, n_names = 0, n_bad = 0, n_trunc = 0;
    int n_live = 0, n_frames = 0, n_configs = 0;

    function automatic void clear_buffer();
        stage     = PH_LEN;
        leb_acc   = 0;
        leb_shift = 0;
        op_end    = 0;
        held_used = 0;
        opc_seen  = 8'h00;
        addr_left = 0;
        field_idx = 0;
        arg_val   = 0;
        arg_ok    = 1'b0;
        rx_count  = 0;
    endfunction

    function automatic int unsigned addr_size_now();
        int unsigned s;
        s = (cfg.header_version >= DWARF_V5) ? cfg.header_address_size
                                             : cfg.target_address_size;
        if (s == 0)
            return 1;
        if (s > 8)
            return 8;
        return s;
    endfunction

    // returns 1 when the number is complete
    function automatic bit leb_take(input logic [7:0] b);
        if (leb_shift > 63)
            return 1'b1;
        leb_acc |= 64'(b[6:0]) << leb_shift;
        leb_shift += 7;
        return !b[7];
    endfunction

    function automatic void close_op(input logic last);
        if (last)
            clear_buffer();
        else
            stage = PH_DRAIN;
    endfunction

    function automatic bit give_bad(input logic last, output t_result r);
        r        = '0;
        r.kind   = KIND_FINAL;
        r.status = ST_BAD_LENGTH;
        close_op(last);
        return 1'b1;
    endfunction

    // final word, held back until the length check is settled
    function automatic bit give_final(input logic last, input logic [1:0] st,
                                      input longint unsigned used,
                                      input logic [7:0] nb, output t_result r);
        r = '0;
        if (rx_count < op_end) begin
            if (last)
                return give_bad(last, r);
            held_used = used;
            stage     = PH_WAIT;
            return 1'b0;
        end
        r.kind       = KIND_FINAL;
        r.opcode     = opc_seen;
        r.argument   = arg_ok ? arg_val : 64'd0;
        r.arg_valid  = arg_ok;
        r.name_byte  = nb;
        r.bytes_used = CNT_W'(used);
        r.status     = st;
        close_op(last);
        return 1'b1;
    endfunction

    function automatic bit trail_step(input logic [7:0] b, input logic last,
                                      output t_result r);
        r = '0;
        if (leb_take(b)) begin
            if (field_idx == 0) begin
                arg_val = leb_acc;
                arg_ok  = 1'b1;
            end
            if (field_idx >= 2 || last)
                return give_final(last, ST_OK, rx_count, 8'h00, r);
            field_idx++;
            stage = PH_TSTART;
            return 1'b0;
        end
        if (last)
            return give_final(last, ST_TRUNCATED, rx_count, 8'h00, r);
        stage = PH_TRAIL;
        return 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output t_result r);
        longint unsigned len;
        r = '0;
        if (stage != PH_DRAIN)
            n_live++;
        if (rx_count < MAX_BUFFER_BYTES)
            rx_count++;
        case (stage)
            PH_LEN: begin
                if (leb_take(b)) begin
                    len = leb_acc;
                    if (len == 0 || last)
                        return give_bad(last, r);
                    op_end = (len > MAX_BUFFER_BYTES) ? MAX_BUFFER_BYTES + 1
                                                      : rx_count + len;
                    leb_acc   = 0;
                    leb_shift = 0;
                    stage     = PH_OPC;
                    return 1'b0;
                end
                if (last)
                    return give_bad(last, r);
                return 1'b0;
            end
            PH_OPC: begin
                opc_seen  = b;
                arg_val   = 0;
                arg_ok    = 1'b0;
                leb_acc   = 0;
                leb_shift = 0;
                if (b == OP_SET_ADDRESS) begin
                    addr_left = addr_size_now();
                    stage     = PH_ADDR;
                end else if (b == OP_DEFINE_FILE) begin
                    stage = PH_NAME;
                end else if (b == OP_SET_DISCRIMINATOR) begin
                    stage = PH_DISC;
                end else begin
                    return give_final(last, ST_OK, op_end, 8'h00, r);
                end
                if (last)
                    return give_final(last, ST_TRUNCATED, rx_count, 8'h00, r);
                return 1'b0;
            end
            PH_ADDR: begin
                if (cfg.big_endian_mode)
                    arg_val = (arg_val << 8) | 64'(b);
                else
                    arg_val |= 64'(b) << ((8 * leb_shift) & 63);
                leb_shift++;
                if (addr_left > 0)
                    addr_left--;
                if (addr_left == 0) begin
                    arg_ok = 1'b1;
                    return give_final(last, ST_OK, rx_count, 8'h00, r);
                end
                if (last) begin
                    arg_val = 0;
                    return give_final(last, ST_TRUNCATED, rx_count, 8'h00, r);
                end
                return 1'b0;
            end
            PH_DISC: begin
                if (leb_take(b)) begin
                    arg_val = leb_acc;
                    arg_ok  = 1'b1;
                    return give_final(last, ST_OK, rx_count, 8'h00, r);
                end
                if (last)
                    return give_final(last, ST_TRUNCATED, rx_count, 8'h00, r);
                return 1'b0;
            end
            PH_NAME: begin
                if (b == 8'h00) begin
                    if (last)
                        return give_final(last, ST_OK, rx_count, 8'h00, r);
                    field_idx = 0;
                    stage     = PH_TSTART;
                    return 1'b0;
                end
                // a name byte that ends the buffer rides on the final word
                if (last)
                    return give_final(last, ST_TRUNCATED, rx_count, b, r);
                r.kind      = KIND_NAME;
                r.opcode    = opc_seen;
                r.name_byte = b;
                return 1'b1;
            end
            PH_TSTART: begin
                // a field starting on the last byte is not read
                if (last)
                    return give_final(last, ST_OK, rx_count - 1, 8'h00, r);
                leb_acc   = 0;
                leb_shift = 0;
                return trail_step(b, last, r);
            end
            PH_TRAIL:
                return trail_step(b, last, r);
            PH_WAIT:
                return give_final(last, ST_OK, held_used, 8'h00, r);
            default: begin
                if (last)
                    clear_buffer();
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver and result check
    // ------------------------------------------------------------------
    t_rx_mode   rx_mode;
    logic       rx_hold;
    logic [7:0] rx_tick = '0;

    always @(posedge i_clk) begin : result_check
        t_result got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{kind: o_result_kind, opcode: o_opcode_value, argument: o_argument,
                    arg_valid: o_argument_valid, name_byte: o_name_byte,
                    bytes_used: o_bytes_used, status: o_status};
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: unexpected word kind %0d op %02h status %0d",
                             $time, got.kind, got.opcode, got.status);
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (want.kind == KIND_NAME)
                    n_names++;
                else if (want.status == ST_BAD_LENGTH)
                    n_bad++;
                else if (want.status == ST_TRUNCATED)
                    n_trunc++;
                if (got.kind !== want.kind || got.opcode !== want.opcode ||
                    got.argument !== want.argument || got.arg_valid !== want.arg_valid ||
                    got.name_byte !== want.name_byte ||
                    got.bytes_used !== want.bytes_used || got.status !== want.status) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("%0t: mismatch (kind op arg arg_valid name used status)",
                                 $time);
                        $display("  expected %0d %02h %016h %0d %02h %0d %0d",
                                 want.kind, want.opcode, want.argument, want.arg_valid,
                                 want.name_byte, want.bytes_used, want.status);
                        $display("  actual   %0d %02h %016h %0d %02h %0d %0d",
                                 got.kind, got.opcode, got.argument, got.arg_valid,
                                 got.name_byte, got.bytes_used, got.status);
                    end
                end
            end
        end

        rx_tick <= rx_tick + 8'd1;
        if (rx_hold) begin
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:    i_out_ready <= 1'b1;
                RX_COIN:    i_out_ready <= 1'($urandom_range(1, 0));
                RX_SLOW:    i_out_ready <= ($urandom_range(3, 0) == 0);
                default:    i_out_ready <= ((rx_tick % 8'd7) < 8'd4);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    int tx_gap_max    = 0;
    int tx_burst_left = 0;

    task automatic send_byte(input logic [7:0] b, input logic last);
        t_result r;
        if (tx_gap_max > 0 && tx_burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(tx_gap_max, 1)) @(posedge i_clk);
            tx_burst_left = $urandom_range(16, 1);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= b;
        i_last_in_buffer <= last;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        if (parse_byte(b, last, r))
            pending_results.push_back(r);
        if (tx_burst_left > 0)
            tx_burst_left--;
    endtask

    task automatic send_buffer(input logic [7:0] frame[$]);
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
        n_frames++;
    endtask

    function automatic void put_uleb(ref logic [7:0] q[$], input longint unsigned v,
                                     input int pad);
        logic [7:0] b;
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0 || pad > 0)
                b[7] = 1'b1;
            q.push_back(b);
        end while (v != 0);
        // redundant continuation groups
        while (pad > 0) begin
            pad--;
            q.push_back(pad > 0 ? 8'h80 : 8'h00);
        end
    endfunction

    function automatic longint unsigned rand_wide();
        longint unsigned v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(63, 0);
    endfunction

    // length field, then body, optionally cut short, then ignored bytes
    task automatic send_frame(input logic [7:0] body[$], input longint unsigned len,
                              input int pad, input int cut, input int extra);
        logic [7:0] frame[$];
        put_uleb(frame, len, pad);
        frame = {frame, body};
        if (cut > 0 && cut < frame.size())
            frame = frame[0:cut-1];
        repeat (extra) frame.push_back(8'($urandom));
        send_buffer(frame);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(CFG_HEADER_VERSION, CFG_DATA_W'(c.header_version));
        write_reg(CFG_HEADER_ADDRESS_SIZE, c.header_address_size);
        write_reg(CFG_TARGET_ADDRESS_SIZE, c.target_address_size);
        write_reg(CFG_BIG_ENDIAN_MODE, CFG_DATA_W'(c.big_endian_mode));
        cfg = c;
        n_configs++;
    endtask

    // everything accepted has been answered and the pipeline is empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_random_op();
        logic [7:0]      body[$];
        logic [7:0]      opc;
        longint unsigned len;
        int              sel, pad, cut, extra;
        sel = $urandom_range(99, 0);
        if (sel < 6) begin
            // plain noise
            repeat ($urandom_range(6, 1)) body.push_back(8'($urandom));
            send_buffer(body);
            return;
        end
        sel = $urandom_range(9, 0);
        if (sel < 3)
            opc = OP_SET_ADDRESS;
        else if (sel < 6)
            opc = OP_DEFINE_FILE;
        else if (sel < 8)
            opc = OP_SET_DISCRIMINATOR;
        else if (sel < 9)
            opc = 8'($urandom);
        else
            opc = ($urandom_range(1, 0) != 0) ? 8'hff : 8'h00;
        body.push_back(opc);
        case (opc)
            OP_SET_ADDRESS: begin
                if ($urandom_range(9, 0) != 0)
                    repeat (addr_size_now()) body.push_back(8'($urandom));
                else
                    repeat ($urandom_range(8, 1)) body.push_back(8'($urandom));
            end
            OP_DEFINE_FILE: begin
                repeat ($urandom_range(6, 0)) body.push_back(8'($urandom_range(255, 1)));
                if ($urandom_range(9, 0) != 0)
                    body.push_back(8'h00);
                repeat ($urandom_range(3, 0))
                    put_uleb(body, ($urandom_range(1, 0) != 0) ? $urandom_range(300, 0)
                                                               : rand_wide(),
                             ($urandom_range(7, 0) == 0) ? 1 : 0);
            end
            OP_SET_DISCRIMINATOR:
                put_uleb(body, rand_wide(),
                         ($urandom_range(9, 0) == 0) ? $urandom_range(10, 1) : 0);
            default:
                repeat ($urandom_range(5, 0)) body.push_back(8'($urandom));
        endcase
        sel = $urandom_range(19, 0);
        if (sel == 0)
            len = 0;
        else if (sel == 1)
            len = body.size() + $urandom_range(3, 1);
        else if (sel == 2)
            len = (body.size() > 2) ? body.size() - $urandom_range(2, 1) : 1;
        else if (sel == 3)
            len = rand_wide() | 64'h2_0000;
        else
            len = body.size();
        pad   = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 1) : 0;
        cut   = ($urandom_range(7, 0) == 0) ? $urandom_range(body.size() + 1, 1) : 0;
        extra = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
        send_frame(body, len, pad, cut, extra);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [7:0] body[$];
        body = {OP_SET_ADDRESS, 8'hff, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h80};
        send_frame(body, body.size(), 0, 0, 0);
        // same address with a length shorter than the operand
        send_frame(body, 2, 0, 0, 0);
        body = {OP_SET_DISCRIMINATOR, 8'h7f};
        send_frame(body, body.size(), 2, 0, 0);
        // eleventh group ends the number, upper bits dropped
        body = {OP_SET_DISCRIMINATOR};
        repeat (12) body.push_back(8'hff);
        body.push_back(8'h01);
        send_frame(body, body.size(), 0, 0, 0);
        body = {OP_DEFINE_FILE, 8'h61, 8'h62, 8'h00, 8'h85, 8'h01, 8'h00, 8'h7f};
        send_frame(body, body.size(), 0, 0, 0);
        // trailing field starts on the last byte
        body = {OP_DEFINE_FILE, 8'h78, 8'h00, 8'h05};
        send_frame(body, body.size(), 0, 0, 0);
        // name runs into the end of the buffer
        body = {OP_DEFINE_FILE, 8'h61, 8'hff};
        send_frame(body, body.size(), 0, 0, 0);
        body = {OP_DEFINE_FILE, 8'h61, 8'h00};
        send_frame(body, body.size(), 0, 0, 0);
        body = {OP_DEFINE_FILE, 8'h00, 8'h80, 8'h80};
        send_frame(body, body.size(), 0, 0, 0);
        body = {OP_SET_ADDRESS, 8'h11, 8'h22, 8'h33};
        send_frame(body, body.size(), 0, 0, 0);
        body = {OP_SET_ADDRESS};
        send_frame(body, body.size(), 0, 0, 0);
        body = {OP_SET_DISCRIMINATOR, 8'h80};
        send_frame(body, body.size(), 0, 0, 0);
        body = {8'h00};
        send_frame(body, body.size(), 0, 0, 0);
        body = {8'hff, 8'h01, 8'h02, 8'h03};
        send_frame(body, body.size(), 0, 0, 3);
        // zero length, too long, far too long
        body = {8'h01};
        send_frame(body, 0, 0, 0, 2);
        body = {OP_SET_DISCRIMINATOR, 8'h05};
        send_frame(body, body.size() + 3, 0, 0, 0);
        body = {8'h10};
        send_frame(body, 64'd1 << 40, 0, 0, 0);
        // long length satisfied by bytes past the operand
        body = {8'h20};
        send_frame(body, 3, 0, 0, 4);
        // length field is the whole buffer
        body = {8'h05};
        send_buffer(body);
        body = {8'h85};
        send_buffer(body);
        wait_idle();
    endtask

    task automatic test_address_modes();
        t_cfg       modes[6];
        logic [7:0] body[$];
        modes[0] = '{header_version: 3'd2, header_address_size: 4'd1,
                     target_address_size: 4'd1, big_endian_mode: 1'b0};
        modes[1] = '{header_version: 3'd5, header_address_size: 4'd1,
                     target_address_size: 4'd8, big_endian_mode: 1'b1};
        modes[2] = '{header_version: 3'd5, header_address_size: 4'd0,
                     target_address_size: 4'd3, big_endian_mode: 1'b0};
        modes[3] = '{header_version: 3'd3, header_address_size: 4'd8,
                     target_address_size: 4'd15, big_endian_mode: 1'b1};
        modes[4] = '{header_version: 3'd7, header_address_size: 4'd8,
                     target_address_size: 4'd0, big_endian_mode: 1'b1};
        modes[5] = '{header_version: 3'd2, header_address_size: 4'd15,
                     target_address_size: 4'd0, big_endian_mode: 1'b0};
        foreach (modes[m]) begin
            load_config(modes[m]);
            body = {OP_SET_ADDRESS};
            repeat (addr_size_now()) body.push_back(8'($urandom));
            send_frame(body, body.size(), 0, 0, 0);
            body = {OP_SET_ADDRESS, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hab, 8'hcd, 8'hef};
            send_frame(body, body.size(), 0, 0, 1);
            wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        t_cfg c;
        int   target;
        for (int p = 0; p < 4; p++) begin
            c.header_version      = 3'($urandom_range(5, 2));
            c.header_address_size = ($urandom_range(2, 0) == 0) ? 4'($urandom)
                                                                : 4'($urandom_range(8, 1));
            c.target_address_size = ($urandom_range(2, 0) == 0) ? 4'($urandom)
                                                                : 4'($urandom_range(8, 1));
            c.big_endian_mode     = 1'($urandom);
            load_config(c);
            case (p)
                0: begin tx_gap_max = 0;  rx_mode <= RX_OPEN;    end
                1: begin tx_gap_max = 4;  rx_mode <= RX_COIN;    end
                2: begin tx_gap_max = 10; rx_mode <= RX_SLOW;    end
                default: begin tx_gap_max = 2; rx_mode <= RX_PATTERN; end
            endcase
            target = n_live + 375;
            while (n_live < target)
                send_random_op();
            wait_idle();
        end
    endtask

    // hold the receiver off while name words keep coming
    task automatic test_backpressure();
        logic [7:0] body[$];
        tx_gap_max = 0;
        rx_mode   <= RX_COIN;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (400) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            repeat (6) begin
                body = {OP_DEFINE_FILE};
                repeat (20) body.push_back(8'($urandom_range(255, 1)));
                body.push_back(8'h00);
                put_uleb(body, $urandom_range(1000, 0), 0);
                put_uleb(body, rand_wide(), 0);
                put_uleb(body, $urandom_range(9, 0), 0);
                send_frame(body, body.size(), 0, 0, 0);
            end
        join
        wait_idle();
    endtask

    // past the point where the byte count saturates
    task automatic test_long_buffers();
        logic [7:0] body[$];
        tx_gap_max = 0;
        rx_mode   <= RX_OPEN;
        body = {8'h55};
        repeat (65532) body.push_back(8'($urandom));
        send_frame(body, body.size(), 0, 0, 6);
        body.push_back(8'h3c);
        send_frame(body, body.size(), 0, 0, 0);
        wait_idle();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_data_byte      <= 8'h00;
        i_last_in_buffer <= 1'b0;
        i_out_ready      <= 1'b0;
        rx_mode          <= RX_OPEN;
        rx_hold          <= 1'b0;
        cfg = CFG_RESET;
        clear_buffer();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_address_modes();
        test_random_traffic();
        test_backpressure();
        test_long_buffers();
        wait_idle();

        $display("covered %0d buffers, %0d parsed bytes, %0d register settings",
                 n_frames, n_live, n_configs);
        $display("checked %0d result words: %0d name, %0d bad length, %0d truncated",
                 n_results, n_names, n_bad, n_trunc);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("tb_dwarf_line_ext_opcode_parser: done, clean");
        else
            $display("tb_dwarf_line_ext_opcode_parser: done, errors");
        $finish;
    end

endmodule

// File: files.f
design/dleo_pkg.sv
design/dleo_leb.sv
design/dleo_step.sv
design/dwarf_line_ext_opcode_parser.sv
bench/tb_dwarf_line_ext_opcode_parser.sv
